>>> rtl/mtl_pkg.sv
// Shared types and constants of the running median block.
`timescale 1ns / 1ps

package mtl_pkg;

    // Width of one latency sample and of the median.
    localparam int unsigned SAMPLE_W = 32;
    // Width of the probe index on the result stream.
    localparam int unsigned PROBE_W  = 6;
    // Width of the packed result word: median and probe index, padded to bytes.
    localparam int unsigned RES_W    = ((SAMPLE_W + PROBE_W + 7) / 8) * 8;

    // Completion of one group, passed from the insertion engine to the top level.
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] median;
    } t_result;

endpackage

>>> rtl/median_of_trial_latencies_top.sv
// Top level of the running median block: stream ports, group counter, result register.
`timescale 1ns / 1ps

// Each request on the input stream carries one 32-bit unsigned latency sample,
// which is inserted into an ascending sorted store of TRIALS entries held in a
// single-port-write, registered-read RAM. A single comparator walks down the
// store one entry per cycle while ready stays low, so no new sample is taken
// until the last one is placed; the first sample of a group goes straight in.
// Once the TRIALS-th sample of a group is placed, the block reads the middle entry
// (position TRIALS/2, the upper middle for even TRIALS) into the output
// register, which holds the median and the group's probe index until taken.
// The probe index wraps to zero after MAX_GROUPS groups. If the previous
// result has not been taken when a group completes, the block waits for it.
module median_of_trial_latencies_top #(
    parameter int unsigned TRIALS     = 33,
    parameter int unsigned MAX_GROUPS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // Fields from bit 0: sample[31:0].
    input  logic [mtl_pkg::SAMPLE_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Fields from bit 0: median[31:0], probe_index[37:32], zero padding[39:38].
    output logic [mtl_pkg::RES_W-1:0]    m_axis_tdata
);

    localparam int unsigned AW = (TRIALS > 1) ? $clog2(TRIALS) : 1;
    localparam logic [mtl_pkg::PROBE_W-1:0] LAST_GROUP = mtl_pkg::PROBE_W'(MAX_GROUPS - 1);

    mtl_pkg::t_result                w_res;
    logic                            r_out_valid;
    logic [mtl_pkg::SAMPLE_W-1:0]    r_median;
    logic [mtl_pkg::PROBE_W-1:0]     r_probe;
    logic [mtl_pkg::PROBE_W-1:0]     r_group, n_group;

    mtl_insert #(
        .TRIALS (TRIALS),
        .AW     (AW)
    ) u_insert (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_sample   (s_axis_tdata),
        .i_out_free (!r_out_valid),
        .o_res      (w_res)
    );

    // Group counter wraps after the last group.
    assign n_group = (r_group == LAST_GROUP) ? '0 : r_group + mtl_pkg::PROBE_W'(1);

    // Output register and group counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_group     <= '0;
        end else begin
            if (w_res.valid) begin
                r_out_valid <= 1'b1;
                r_group     <= n_group;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_median <= w_res.median;
            r_probe  <= r_group;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(mtl_pkg::RES_W - mtl_pkg::SAMPLE_W - mtl_pkg::PROBE_W){1'b0}},
                            r_probe, r_median};

    // A result is only produced into an empty output register.
    a_res_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> !r_out_valid)
        else $error("result produced while output register full");

    // A waiting result stays offered and unchanged until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("waiting result dropped or changed before it was taken");

    // A produced result carries the group number current at completion.
    a_probe_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |=> (m_axis_tvalid && r_probe == $past(r_group)))
        else $error("result not registered with its group number");

endmodule

>>> rtl/mtl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mtl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 33,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mtl_insert.sv
// Insertion sort engine: one compare unit stepping through the sorted store.
`timescale 1ns / 1ps

module mtl_insert #(
    parameter int unsigned TRIALS = 33,
    parameter int unsigned AW     = (TRIALS > 1) ? $clog2(TRIALS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mtl_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                          i_out_free,
    output mtl_pkg::t_result              o_res
);

    localparam logic [AW-1:0] LAST_POS = AW'(TRIALS - 1);
    localparam logic [AW-1:0] MID_POS  = AW'(TRIALS / 2);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_PLACE = 5'b00100,
        S_MEDRD = 5'b01000,
        S_MEDLD = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [AW-1:0]                r_fill, n_fill;
    logic [AW-1:0]                r_pos, n_pos;
    logic [mtl_pkg::SAMPLE_W-1:0] r_sample, n_sample;

    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [mtl_pkg::SAMPLE_W-1:0] w_wdata;
    logic [AW-1:0]                w_raddr;
    logic [mtl_pkg::SAMPLE_W-1:0] w_rdata;
    logic                         w_last;

    mtl_ram #(
        .WIDTH (mtl_pkg::SAMPLE_W),
        .DEPTH (TRIALS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The sample being placed completes the group.
    assign w_last = (r_fill == LAST_POS);

    // Sequencer: each step compares one stored entry with the new sample and
    // either moves that entry up by one place or drops the sample in.
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_pos        = r_pos;
        n_sample     = r_sample;
        w_we         = 1'b0;
        w_waddr      = r_pos;
        w_wdata      = r_sample;
        w_raddr      = r_pos - AW'(1);
        o_ready      = 1'b0;
        o_res.valid  = 1'b0;
        o_res.median = w_rdata;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_sample = i_sample;
                    n_pos    = r_fill;
                    w_raddr  = r_fill - AW'(1);
                    if (r_fill == '0) begin
                        // Empty store: the sample goes straight to the bottom.
                        w_we    = 1'b1;
                        w_waddr = '0;
                        w_wdata = i_sample;
                        if (w_last) begin
                            n_fill  = '0;
                            n_state = S_MEDRD;
                        end else begin
                            n_fill  = r_fill + AW'(1);
                        end
                    end else begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                w_we = 1'b1;
                if (w_rdata > r_sample) begin
                    // Entry below is larger: move it up and look one lower.
                    w_wdata = w_rdata;
                    n_pos   = r_pos - AW'(1);
                    w_raddr = r_pos - AW'(1) - AW'(1);
                    if (r_pos == AW'(1)) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    // Entry below is not larger: the sample belongs here.
                    if (w_last) begin
                        n_fill  = '0;
                        n_state = S_MEDRD;
                    end else begin
                        n_fill  = r_fill + AW'(1);
                        n_state = S_IDLE;
                    end
                end
            end
            S_PLACE: begin
                w_we = 1'b1;
                if (w_last) begin
                    n_fill  = '0;
                    n_state = S_MEDRD;
                end else begin
                    n_fill  = r_fill + AW'(1);
                    n_state = S_IDLE;
                end
            end
            S_MEDRD: begin
                // Wait for the output register, then fetch the middle entry.
                w_raddr = MID_POS;
                if (i_out_free) begin
                    n_state = S_MEDLD;
                end
            end
            S_MEDLD: begin
                o_res.valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // Working registers of the current insertion.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_sample <= n_sample;
    end

endmodule
